### rtl/wsd_pkg.sv
// Shared package of the windowed-sinc decimator: sample width, default parameters,
// the MAC control struct and the elaboration-time kernel math (Q30 sin, sinc, Hamming).
// Depends on nothing.
package wsd_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int DECIMATION_DEF = 4;
	localparam int TAPS_DEF       = 31;
	localparam int COEF_BITS_DEF  = 18;

	localparam logic [63:0] PI_Q28     = 64'd843314856;
	localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30    = 64'd1073741824;
	localparam logic [63:0] HAM_A_Q30  = 64'd579820585;
	localparam logic [63:0] HAM_B_Q30  = 64'd493921239;

	// Per-cycle command that travels from the sequencer to the MAC.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctrl_t;

	// Restoring long division, used only while the coefficient table is built.
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] umod(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
			end
		end
		return rem[63:0];
	endfunction

	// sin(2*pi*num/den) in Q30: quadrant reduction, then a Taylor series to x^15.
	function automatic logic signed [63:0] sin_q30(input logic [63:0] num,
			input logic [63:0] den);
		logic [63:0]        r;
		logic [63:0]        q;
		logic [63:0]        rem;
		logic [63:0]        a;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		r   = umod(num, den);
		q   = udiv(r << 2, den);
		rem = (r << 2) - q * den;
		if (q[0]) begin
			rem = den - rem;
		end
		a    = udiv(rem * HALFPI_Q30, den);
		x2   = (a * a) >> 30;
		term = a;
		sum  = $signed(a);
		for (int k = 1; k <= 7; k++) begin
			term = udiv((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
			if (k[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return (q >= 64'd2) ? -sum : sum;
	endfunction

	// sin(pi*t/dec) / (pi*t/dec) in Q30, quotient rounded to nearest.
	function automatic logic signed [63:0] sinc_q30(input logic signed [63:0] t,
			input logic [63:0] dec);
		logic [63:0]        mag;
		logic signed [63:0] s;
		logic [63:0]        sa;
		logic [63:0]        numer;
		logic [63:0]        dn;
		logic [63:0]        qv;
		mag = (t < 0) ? $unsigned(-t) : $unsigned(t);
		if (mag == 64'd0) begin
			return $signed(ONE_Q30);
		end
		s     = sin_q30(mag, dec << 1);
		sa    = (s < 0) ? $unsigned(-s) : $unsigned(s);
		numer = (sa * dec) << 28;
		dn    = PI_Q28 * mag;
		qv    = udiv(numer + (dn >> 1), dn);
		return (s < 0) ? -$signed(qv) : $signed(qv);
	endfunction

	// Kernel length: two taps shorter when the centre offset is a nonzero multiple of dec.
	function automatic int calc_ntaps(input int taps, input int dec);
		int n;
		int pad;
		n   = taps;
		pad = (taps - 1) >> 1;
		if (pad > 0 && umod(64'(pad), 64'(dec)) == 64'd0) begin
			n = n - 2;
		end
		return n;
	endfunction

	// One windowed-sinc coefficient in Q(cbits-1), rounded half away from zero and saturated.
	function automatic logic signed [63:0] coef_val(input int i, input int ntaps,
			input int dec, input int cbits);
		int                 pad;
		int                 sh;
		logic signed [63:0] cap;
		logic signed [63:0] c;
		logic [63:0]        cm;
		logic [63:0]        m;
		logic signed [63:0] w;
		logic signed [63:0] tt;
		logic signed [63:0] sn;
		logic signed [63:0] prod;
		logic [63:0]        pm;
		logic signed [63:0] r;
		pad  = (ntaps - 1) >> 1;
		sh   = 61 - cbits;
		cap  = 64'sd1 <<< (cbits - 1);
		c    = sin_q30(64'(4 * i + ntaps), 64'(4 * ntaps));
		cm   = (c < 0) ? $unsigned(-c) : $unsigned(c);
		m    = (HAM_B_Q30 * cm + (64'd1 << 29)) >> 30;
		w    = (c < 0) ? $signed(HAM_A_Q30 + m) : $signed(HAM_A_Q30 - m);
		tt   = 64'(i - pad);
		sn   = sinc_q30(tt, 64'(dec));
		prod = sn * w;
		pm   = (prod < 0) ? $unsigned(-prod) : $unsigned(prod);
		r    = $signed((pm + (64'd1 << (sh - 1))) >> sh);
		if (prod < 0) begin
			if (r > cap) begin
				r = cap;
			end
			r = -r;
		end else if (r >= cap) begin
			r = cap - 64'sd1;
		end
		return r;
	endfunction

endpackage

### rtl/wsd_ram.sv
// Delay-line memory of the windowed-sinc decimator: one write port, one read port,
// registered read data. Depends on wsd_pkg for the sample width.
module wsd_ram #(
	parameter int DEPTH = wsd_pkg::TAPS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [wsd_pkg::SAMPLE_W-1:0] wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [wsd_pkg::SAMPLE_W-1:0] rdata
);
	import wsd_pkg::*;

	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/wsd_mac.sv
// Shared multiply-accumulate of the windowed-sinc decimator, with the constant
// coefficient table, rounding and saturation. Depends on wsd_pkg.
module wsd_mac #(
	parameter int DECIMATION = wsd_pkg::DECIMATION_DEF,
	parameter int TAPS       = wsd_pkg::TAPS_DEF,
	parameter int COEF_BITS  = wsd_pkg::COEF_BITS_DEF,
	localparam int NTAPS     = wsd_pkg::calc_ntaps(TAPS, DECIMATION),
	localparam int IDX_W     = (NTAPS > 1) ? $clog2(NTAPS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wsd_pkg::mac_ctrl_t                  ctrl,
	input  logic [IDX_W-1:0]                    coef_idx,
	input  logic signed [wsd_pkg::SAMPLE_W-1:0] rd_sample,
	output logic                                done,
	output logic signed [wsd_pkg::SAMPLE_W-1:0] result
);
	import wsd_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_BITS;
	localparam int ACC_W  = PROD_W + $clog2(NTAPS) + 1;

	typedef logic signed [COEF_BITS-1:0] coef_tab_t [NTAPS];

	function automatic coef_tab_t build_tab();
		coef_tab_t          tab;
		logic signed [63:0] cv;
		for (int i = 0; i < NTAPS; i++) begin
			cv     = coef_val(i, NTAPS, DECIMATION, COEF_BITS);
			tab[i] = cv[COEF_BITS-1:0];
		end
		return tab;
	endfunction

	localparam coef_tab_t COEF_TAB = build_tab();

	localparam logic signed [ACC_W-1:0] RND_C  = ACC_W'(64'sd1 <<< (COEF_BITS - 2));
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

	mac_ctrl_t                  ctrl_s1;
	mac_ctrl_t                  ctrl_s2;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_q;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shf;

	// Stage 1 lines up the coefficient with the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			done_q  <= ctrl_s2.valid && ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= COEF_TAB[coef_idx];
		prod_s2 <= PROD_W'(rd_sample) * PROD_W'(coef_s1);
		if (ctrl_s2.valid) begin
			if (ctrl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	always_comb begin
		rnd = acc_q + RND_C;
		shf = rnd >>> (COEF_BITS - 1);
		if (shf > SAT_HI) begin
			result = SAT_HI[SAMPLE_W-1:0];
		end else if (shf < SAT_LO) begin
			result = SAT_LO[SAMPLE_W-1:0];
		end else begin
			result = shf[SAMPLE_W-1:0];
		end
	end

	assign done = done_q;

endmodule

### rtl/windowed_sinc_decimator.sv
// Top level of the windowed-sinc decimator: handshake, delay-line sequencer, output register.
// Depends on wsd_pkg, wsd_ram and wsd_mac.
//
// Streaming decimating FIR with a Hamming-windowed sinc kernel and signed Q1.15 samples.
// Every input transaction writes its sample into a circular delay line held in a
// synchronous RAM. After the kernel's NTAPS samples have arrived, every DECIMATION-th
// sample starts one output: the sequencer reads the delay line oldest sample first, one
// entry per cycle, and a single shared multiplier/accumulator sums sample times
// coefficient. The coefficients are constants fixed at elaboration from the parameters.
// A sample that yields no output leaves the block ready for the next one. A sample
// that yields an output keeps in_ready low after its transaction while the sequencer
// reads all NTAPS entries through the one RAM read port and the one multiplier and
// then waits for the sum to leave the MAC pipeline. The input is not taken while the
// MAC sequence runs, so reads and writes of the delay line never touch the same entry
// in one cycle.
// A finished output waits in its own register, and new samples are still accepted
// meanwhile. If the next sum is done while that register is still occupied, the
// sequencer holds the sum and keeps in_ready low until the waiting output transaction
// completes. With DECIMATION = 1 the block passes every sample straight through its
// output register.
// The delay line needs no clearing after reset: no entry is read before it is written.
module windowed_sinc_decimator #(
	parameter int DECIMATION = wsd_pkg::DECIMATION_DEF,
	parameter int TAPS       = wsd_pkg::TAPS_DEF,
	parameter int COEF_BITS  = wsd_pkg::COEF_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [wsd_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wsd_pkg::SAMPLE_W-1:0] sample_out
);
	import wsd_pkg::*;

	localparam int NTAPS   = calc_ntaps(TAPS, DECIMATION);
	localparam int IDX_W   = (NTAPS > 1) ? $clog2(NTAPS) : 1;
	localparam int FILL_W  = $clog2(NTAPS + 1);
	localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam bit PASS    = (DECIMATION == 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                     state_q;
	state_t                     state_nxt;
	logic [IDX_W-1:0]           wp_q;
	logic [IDX_W-1:0]           wp_nxt;
	logic [IDX_W-1:0]           rd_addr_q;
	logic [IDX_W-1:0]           rd_addr_nxt;
	logic [IDX_W-1:0]           cnt_q;
	logic [FILL_W-1:0]          fill_q;
	logic [PHASE_W-1:0]         phase_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic                       slot_free;
	logic                       in_fire;
	logic                       fill_full;
	logic                       now_full;
	logic                       due;
	logic                       cnt_last;
	logic                       load_mac;
	logic                       load_pass;
	mac_ctrl_t                  mac_ctrl;
	logic signed [SAMPLE_W-1:0] rd_sample;
	logic                       mac_done;
	logic signed [SAMPLE_W-1:0] mac_result;

	always_comb begin
		// The output register is free when empty or when its transaction completes now.
		slot_free   = !out_valid_q || out_ready;
		in_ready    = (state_q == ST_IDLE) && (slot_free || !PASS);
		in_fire     = in_valid && in_ready;
		fill_full   = (fill_q == FILL_W'(NTAPS));
		now_full    = fill_full || (fill_q == FILL_W'(NTAPS - 1));
		due         = now_full && (phase_q == '0);
		wp_nxt      = (wp_q == IDX_W'(NTAPS - 1)) ? '0 : wp_q + IDX_W'(1);
		rd_addr_nxt = (rd_addr_q == IDX_W'(NTAPS - 1)) ? '0 : rd_addr_q + IDX_W'(1);
		cnt_last    = (cnt_q == IDX_W'(NTAPS - 1));
		load_pass   = in_fire && PASS;
		load_mac    = ((state_q == ST_WAIT) && mac_done && slot_free)
		           || ((state_q == ST_HOLD) && slot_free);

		mac_ctrl.valid = (state_q == ST_READ);
		mac_ctrl.first = (cnt_q == '0);
		mac_ctrl.last  = cnt_last;

		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !PASS && due) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				if (cnt_last) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (mac_done) begin
					state_nxt = slot_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rd_addr_q   <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire && !PASS) begin
				wp_q      <= wp_nxt;
				// The oldest sample sits right after the one just written.
				rd_addr_q <= wp_nxt;
				cnt_q     <= '0;
				if (!fill_full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				if (now_full) begin
					phase_q <= (phase_q == PHASE_W'(DECIMATION - 1)) ? '0
					         : phase_q + PHASE_W'(1);
				end
			end else if (state_q == ST_READ) begin
				rd_addr_q <= rd_addr_nxt;
				cnt_q     <= cnt_q + IDX_W'(1);
			end
			if (load_pass || load_mac) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pass) begin
			sample_out_q <= sample_in;
		end else if (load_mac) begin
			sample_out_q <= mac_result;
		end
	end

	wsd_ram #(
		.DEPTH (NTAPS)
	) u_ram (
		.clk   (clk),
		.we    (in_fire && !PASS),
		.waddr (wp_q),
		.wdata (sample_in),
		.re    (mac_ctrl.valid),
		.raddr (rd_addr_q),
		.rdata (rd_sample)
	);

	wsd_mac #(
		.DECIMATION (DECIMATION),
		.TAPS       (TAPS),
		.COEF_BITS  (COEF_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.coef_idx  (cnt_q),
		.rd_sample (rd_sample),
		.done      (mac_done),
		.result    (mac_result)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// A finished sum only ever arrives while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_WAIT))
		else $error("MAC finished outside the wait state");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(NTAPS))
		else $error("fill count ran past the kernel length");

	// The decimation phase only moves once the delay line is full.
	a_phase_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != '0) |-> fill_full)
		else $error("decimation phase advanced during warm-up");

	a_pass_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && PASS) |=> out_valid)
		else $error("pass-through sample did not reach the output");

endmodule

### dv/tb.sv
// Self-checking testbench for windowed_sinc_decimator at its default build (D=4, 31 taps, Q1.17).
// It builds its own copy of the windowed-sinc kernel and a delay-line predictor of the filter.
// Depends on the RTL in rtl/ (wsd_pkg and windowed_sinc_decimator with its submodules).
module tb;

	// Build of the device under test. The predictor below works from the same numbers.
	localparam int DECIM   = 4;
	localparam int TAPS    = 31;
	localparam int CBITS   = 18;
	localparam int SW      = wsd_pkg::SAMPLE_W;
	localparam int LIMIT   = 400000;
	// Settling wait, a margin above the time the block stays busy after a transaction that starts an output.
	localparam int SETTLE  = TAPS + 40;

	// Fixed-point constants of the kernel math, all in Q30 unless named otherwise.
	localparam bit [63:0] PI_Q28      = 64'd843314856;
	localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam longint    UNITY_Q30   = 64'sd1073741824;
	localparam bit [63:0] HAM_A_Q30   = 64'd579820585;
	localparam bit [63:0] HAM_B_Q30   = 64'd493921239;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] sample_in  = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic signed [SW-1:0] sample_out;

	// Kernel as the block should hold it, and the filter state that the predictor keeps.
	longint               kernel[TAPS];
	int                   kernel_len;
	logic signed [SW-1:0] history[$];
	int                   phase;

	// Filtered samples still owed by the block, oldest first.
	logic signed [SW-1:0] pending_out[$];

	int errors      = 0;
	int cycles      = 0;
	// Chance in percent that a burst of idle cycles starts, per side.
	int in_idle_pct  = 0;
	int out_idle_pct = 0;

	windowed_sinc_decimator #(
		.DECIMATION(DECIM),
		.TAPS(TAPS),
		.COEF_BITS(CBITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sin(2*pi*num/den) in Q30. The angle is folded into the first quadrant, then a
	// Taylor series up to the x^15 term is summed in integers.
	function automatic longint sine_turn_q30(input bit [63:0] num, input bit [63:0] den);
		bit [63:0] frac;
		bit [63:0] quad;
		bit [63:0] off;
		bit [63:0] ang;
		bit [63:0] ang_sq;
		bit [63:0] term;
		longint    acc;
		frac = num % den;
		quad = (frac * 4) / den;
		off  = frac * 4 - quad * den;
		if (quad[0]) begin
			off = den - off;
		end
		ang    = (off * HALF_PI_Q30) / den;
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		acc    = longint'(ang);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return (quad >= 2) ? -acc : acc;
	endfunction

	// sin(pi*t/D) / (pi*t/D) in Q30, with the quotient rounded to nearest.
	function automatic longint sinc_q30(input int t);
		bit [63:0] mag;
		longint    s;
		bit [63:0] sa;
		bit [63:0] numer;
		bit [63:0] den;
		bit [63:0] quo;
		mag = 64'((t < 0) ? -t : t);
		if (mag == 0) begin
			return UNITY_Q30;
		end
		s     = sine_turn_q30(mag, 64'(2 * DECIM));
		sa    = 64'((s < 0) ? -s : s);
		numer = (sa * DECIM) << 28;
		den   = PI_Q28 * mag;
		quo   = (numer + den / 2) / den;
		return (s < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	// Windowed-sinc taps in Q(CBITS-1). The kernel loses two taps when its centre
	// offset is a nonzero multiple of the decimation factor.
	function automatic void build_kernel();
		int        centre;
		int        sh;
		longint    cap;
		longint    c;
		bit [63:0] cmag;
		bit [63:0] mterm;
		longint    win;
		longint    prod;
		bit [63:0] pmag;
		longint    r;
		kernel_len = TAPS;
		centre     = (TAPS - 1) / 2;
		if (centre > 0 && centre % DECIM == 0) begin
			kernel_len = TAPS - 2;
		end
		centre = (kernel_len - 1) / 2;
		sh     = 61 - CBITS;
		cap    = longint'(1) <<< (CBITS - 1);
		for (int i = 0; i < TAPS; i++) begin
			kernel[i] = 0;
		end
		for (int i = 0; i < kernel_len; i++) begin
			c     = sine_turn_q30(64'(4 * i + kernel_len), 64'(4 * kernel_len));
			cmag  = 64'((c < 0) ? -c : c);
			mterm = (HAM_B_Q30 * cmag + (64'd1 << 29)) >> 30;
			win   = (c < 0) ? longint'(HAM_A_Q30 + mterm) : longint'(HAM_A_Q30 - mterm);
			prod  = sinc_q30(i - centre) * win;
			pmag  = 64'((prod < 0) ? -prod : prod);
			r     = longint'((pmag + (64'd1 << (sh - 1))) >> sh);
			if (prod < 0) begin
				if (r > cap) begin
					r = cap;
				end
				r = -r;
			end else if (r >= cap) begin
				r = cap - 1;
			end
			kernel[i] = r;
		end
	endfunction

	// Shifts one accepted sample into the predicted delay line. Once the kernel is
	// full, every DECIM-th sample owes one output: the dot product of the window
	// (oldest sample first) with the kernel, rounded half up and saturated to 16 bits.
	function automatic void advance_filter(input logic signed [SW-1:0] s);
		longint acc;
		longint r;
		if (DECIM == 1) begin
			pending_out.push_back(s);
			return;
		end
		history.push_back(s);
		if (history.size() > kernel_len) begin
			void'(history.pop_front());
		end
		if (history.size() < kernel_len) begin
			return;
		end
		if (phase != 0) begin
			phase = (phase + 1) % DECIM;
			return;
		end
		phase = (phase + 1) % DECIM;
		acc = 0;
		for (int p = 0; p < kernel_len; p++) begin
			acc += longint'(history[p]) * kernel[p];
		end
		acc += longint'(1) <<< (CBITS - 2);
		r = acc >>> (CBITS - 1);
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		pending_out.push_back(SW'(r));
	endfunction

	// Offers one sample and waits for the transaction. in_valid is lowered only for
	// an idle burst, so back-to-back samples keep it high without a glitch.
	task automatic push_sample(input logic signed [SW-1:0] s);
		int gap;
		if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
			gap = $urandom_range(1, 13);
			in_valid  <= 1'b0;
			sample_in <= SW'($urandom());
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do begin
			@(posedge clk);
		end while (!in_ready);
		advance_filter(s);
	endtask

	// The output side stalls in random bursts. A burst that is under way
	// when idling is switched off still runs to its end.
	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
			out_ready  <= 1'b0;
			stall_left = $urandom_range(1, 13) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every output transaction is matched against the oldest predicted sample.
	always @(posedge clk) begin
		logic signed [SW-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected sample_out, expected none, got %0d",
					$time, sample_out);
				errors++;
			end else begin
				want = pending_out.pop_front();
				if (sample_out !== want) begin
					$display("%0t: sample_out mismatch, expected %0d, got %0d",
						$time, want, sample_out);
					errors++;
				end
			end
		end
	end

	// Warm-up: the first kernel_len samples carry the field extremes and a few
	// patterns; the first output must come on the last of them and not before.
	task automatic test_warmup();
		int warm_vals[31] = '{32767, -32768, 0, -1, 1, 32767, 32767, -32768, -32768,
			16384, -16384, 21845, -21846, 256, -256, 12345, -12345, 32767, 32767,
			32767, 32767, -32768, -32768, -32768, -32768, 0, 0, 1, -1, 32767, -32768};
		in_idle_pct  = 30;
		out_idle_pct = 20;
		foreach (warm_vals[i]) begin
			push_sample(SW'(warm_vals[i]));
		end
	endtask

	// Long runs near full scale drive the accumulator past 16 bits in both
	// directions, so the output saturates at either rail.
	task automatic test_saturation(input int count);
		int                   run;
		logic signed [SW-1:0] level;
		in_idle_pct  = 15;
		out_idle_pct = 15;
		while (count > 0) begin
			run = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0: level = 16'sh7FFF;
				1: level = -16'sh8000;
				2: level = 16'sh7FFF - SW'($urandom_range(0, 255));
				default: level = -16'sh8000 + SW'($urandom_range(0, 255));
			endcase
			for (int k = 0; k < run && count > 0; k++) begin
				push_sample(level);
				count--;
			end
		end
	endtask

	// Sparse impulses over low-level noise: each impulse walks through every tap of
	// the kernel, so the outputs show every DECIM-th coefficient almost on its own.
	task automatic test_impulses(input int count);
		logic signed [SW-1:0] s;
		in_idle_pct  = 25;
		out_idle_pct = 10;
		repeat (count) begin
			if ($urandom_range(0, 15) == 0) begin
				s = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : -16'sh8000;
				if ($urandom_range(0, 2) == 0) begin
					s = SW'($urandom());
				end
			end else begin
				s = SW'(int'($urandom_range(0, 16)) - 8);
			end
			push_sample(s);
		end
	endtask

	// Uniform samples over the whole field, with idling on both sides.
	task automatic test_full_range(input int count);
		in_idle_pct  = 20;
		out_idle_pct = 20;
		repeat (count) begin
			push_sample(SW'($urandom()));
		end
	endtask

	// The closing stretch runs at full rate with no idling on either side.
	task automatic test_full_rate(input int count);
		in_idle_pct  = 0;
		out_idle_pct = 0;
		repeat (count) begin
			push_sample(SW'($urandom()));
		end
	endtask

	initial begin
		build_kernel();
		phase = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_warmup();
		test_saturation(200);
		test_impulses(200);
		test_full_range(320);
		test_full_rate(100);

		in_valid <= 1'b0;
		while (pending_out.size() > 0) begin
			@(posedge clk);
		end
		// Any stray output would show up within one more MAC pass.
		repeat (SETTLE) @(posedge clk);
		if (pending_out.size() > 0) begin
			$display("%0t: %0d results never arrived, next expected %0d",
				$time, pending_out.size(), pending_out[0]);
			errors++;
		end
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
